// File: src/sfb_pkg.sv
// shared constants, types and register codes for the seam feather blend
// no dependencies; used by every other file of the block
package sfb_pkg;

  localparam int unsigned COL_W = 12;  // column and overlap start
  localparam int unsigned WID_W = 13;  // image width and blend span
  localparam int unsigned PIX_W = 8;
  localparam int unsigned NUM_CH = 3;
  localparam int unsigned QUO_W = 8;   // quotient bits, one division cell each
  localparam int unsigned NUM_W = WID_W + QUO_W - 1;  // weighted sum is at most 255 * 4096
  localparam int unsigned PROD_W = NUM_W + 1;

  localparam logic [WID_W-1:0] MaxWidth = 13'd4096;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = WID_W;
  localparam logic [CFG_IDX_W-1:0] CfgOverlapStart = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CfgImageWidth = 2'd1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [NUM_CH-1:0] rgb_t;
  typedef logic [NUM_W-1:0] num_t;

  // one pixel on its way through the divider chain
  typedef struct packed {
    logic blend;
    logic in_ovl;
    rgb_t base;
    num_t [NUM_CH-1:0] rem;
    num_t dsh;
    rgb_t quo;
  } sfb_div_t;

endpackage

// File: src/sfb_if.sv
// pixel input and blended output channels of the seam feather blend
// depends on sfb_pkg for the field widths
interface sfb_in_if;
  import sfb_pkg::*;
  logic valid;
  logic ready;
  logic [COL_W-1:0] column;
  logic [PIX_W-1:0] base_ch0;
  logic [PIX_W-1:0] base_ch1;
  logic [PIX_W-1:0] base_ch2;
  logic [PIX_W-1:0] warp_ch0;
  logic [PIX_W-1:0] warp_ch1;
  logic [PIX_W-1:0] warp_ch2;

  modport source (
    output valid, column, base_ch0, base_ch1, base_ch2, warp_ch0, warp_ch1, warp_ch2,
    input ready
  );
  modport sink (
    input valid, column, base_ch0, base_ch1, base_ch2, warp_ch0, warp_ch1, warp_ch2,
    output ready
  );
endinterface

interface sfb_out_if;
  import sfb_pkg::*;
  logic valid;
  logic ready;
  logic [PIX_W-1:0] out_ch0;
  logic [PIX_W-1:0] out_ch1;
  logic [PIX_W-1:0] out_ch2;
  logic in_overlap;

  modport source (output valid, out_ch0, out_ch1, out_ch2, in_overlap, input ready);
  modport sink (input valid, out_ch0, out_ch1, out_ch2, in_overlap, output ready);
endinterface

// File: src/sfb_front.sv
// front end: overlap test and weights, then weighted sums per channel
// depends on sfb_pkg and sfb_in_if; feeds the first division cell
module sfb_front import sfb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  sfb_in_if.sink           pix_in,
  input  logic [COL_W-1:0] start_i,
  input  logic [WID_W-1:0] width_i,
  output logic             valid_o,
  input  logic             ready_i,
  output sfb_div_t         data_o
);

  logic             a_valid_q;
  logic             a_inside_q, a_blend_q;
  rgb_t             a_base_q, a_warp_q;
  logic [WID_W-1:0] a_den_q, a_wb_q;
  logic [COL_W-1:0] a_ww_q;
  logic             a_ready, b_ready;
  logic             b_valid_q;
  sfb_div_t         b_data_q, b_data_d;

  logic [WID_W-1:0] eff_width, col_ext, start_ext;
  logic             in_span, nonblack;

  assign b_ready      = !b_valid_q || ready_i;
  assign a_ready      = !a_valid_q || b_ready;
  assign pix_in.ready = a_ready;
  assign valid_o      = b_valid_q;
  assign data_o       = b_data_q;

  always_comb begin
    eff_width = (width_i > MaxWidth) ? MaxWidth : width_i;
    col_ext   = {1'b0, pix_in.column};
    start_ext = {1'b0, start_i};
    in_span   = (col_ext >= start_ext) && (col_ext < eff_width);
    nonblack  = |{pix_in.warp_ch0, pix_in.warp_ch1, pix_in.warp_ch2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= pix_in.valid;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && pix_in.valid) begin
      a_inside_q <= in_span;
      a_blend_q  <= in_span && nonblack;
      a_base_q   <= {pix_in.base_ch2, pix_in.base_ch1, pix_in.base_ch0};
      a_warp_q   <= {pix_in.warp_ch2, pix_in.warp_ch1, pix_in.warp_ch0};
      // only meaningful inside the overlap, where none of these wrap
      a_den_q    <= eff_width - start_ext;
      a_wb_q     <= eff_width - col_ext;
      a_ww_q     <= pix_in.column - start_i;
    end
  end

  always_comb begin
    logic [PROD_W-1:0] sum;
    b_data_d        = '0;
    b_data_d.blend  = a_blend_q;
    b_data_d.in_ovl = a_inside_q;
    b_data_d.base   = a_base_q;
    b_data_d.quo    = '0;
    // divisor lined up with the top quotient bit
    b_data_d.dsh    = {a_den_q, {(QUO_W-1){1'b0}}};
    for (int k = 0; k < NUM_CH; k++) begin
      sum = PROD_W'(a_base_q[k]) * PROD_W'(a_wb_q)
          + PROD_W'(a_warp_q[k]) * PROD_W'(a_ww_q);
      b_data_d.rem[k] = sum[NUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) b_data_q <= b_data_d;
  end

endmodule

// File: src/sfb_div_cell.sv
// one restoring division cell: settles one quotient bit for all three channels
// depends on sfb_pkg; chained eight deep in the top level
module sfb_div_cell import sfb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  sfb_div_t data_i,
  output logic     valid_o,
  input  logic     ready_i,
  output sfb_div_t data_o
);

  logic     valid_q;
  sfb_div_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    logic [NUM_W:0] diff;
    data_d     = data_i;
    data_d.dsh = data_i.dsh >> 1;
    for (int k = 0; k < NUM_CH; k++) begin
      diff = {1'b0, data_i.rem[k]} - {1'b0, data_i.dsh};
      data_d.quo[k] = {data_i.quo[k][PIX_W-2:0], !diff[NUM_W]};
      if (!diff[NUM_W]) data_d.rem[k] = diff[NUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

endmodule

// File: src/seam_feather_blend.sv
// seam feather blend top: config registers, front end, chain of division cells
// depends on sfb_pkg, sfb_in_if, sfb_out_if, sfb_front and sfb_div_cell
//
//   channel    dir  beat
//   pix_in     in   column, base pixel, warped pixel
//   pix_out    out  blended pixel, in_overlap flag
//   cfg        in   write enable, index, data (no handshake)
//
// one pixel per clock sustained while pix_out.ready holds; from input beat to output beat:
// two front stages (weights, then multiply-add) and eight division cells,
// one quotient bit each; the last cell register is the output register
// every stage has its own valid and fills bubbles, so input keeps flowing
// while a result waits until all ten stages hold a pixel; reset empties
// the pipe, config resets to start 0 and width 4096
module seam_feather_blend import sfb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sfb_in_if.sink                pix_in,
  sfb_out_if.source             pix_out,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [COL_W-1:0] start_q;
  logic [WID_W-1:0] width_q;

  logic     valid [QUO_W+1];
  logic     ready [QUO_W+1];
  sfb_div_t data  [QUO_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      width_q <= MaxWidth;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOverlapStart: start_q <= cfg_wdata_i[COL_W-1:0];
        CfgImageWidth:   width_q <= cfg_wdata_i[WID_W-1:0];
        default: ;
      endcase
    end
  end

  sfb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_in  (pix_in),
    .start_i (start_q),
    .width_i (width_q),
    .valid_o (valid[0]),
    .ready_i (ready[0]),
    .data_o  (data[0])
  );

  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    sfb_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[i]),
      .ready_o (ready[i]),
      .data_i  (data[i]),
      .valid_o (valid[i+1]),
      .ready_i (ready[i+1]),
      .data_o  (data[i+1])
    );
  end

  assign ready[QUO_W]       = pix_out.ready;
  assign pix_out.valid      = valid[QUO_W];
  // black warped pixel or outside the overlap: base passes through
  assign pix_out.out_ch0    = data[QUO_W].blend ? data[QUO_W].quo[0] : data[QUO_W].base[0];
  assign pix_out.out_ch1    = data[QUO_W].blend ? data[QUO_W].quo[1] : data[QUO_W].base[1];
  assign pix_out.out_ch2    = data[QUO_W].blend ? data[QUO_W].quo[2] : data[QUO_W].base[2];
  assign pix_out.in_overlap = data[QUO_W].in_ovl;

endmodule
